@@ rtl/ifsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ifsc_pkg: shared definitions for the chaos-game point plotter
// Widths, register index codes, frame defaults and the multiply-accumulate
// operation record passed from the sequencer to the shared arithmetic unit.
// ----------------------------------------------------------------------------
package ifsc_pkg;

  // Fixed-point formats: coefficients are Q2.14, the point is Q6.14.
  localparam int FRAC_BITS = 14;
  localparam int COEF_W    = 16;
  localparam int PT_W      = 20;
  localparam int PROD_W    = COEF_W + PT_W;
  // Two products plus a shifted 16-bit offset fit with margin in 38 bits.
  localparam int ACC_W     = PROD_W + 2;
  localparam int PIX_W     = 16;
  localparam int RAND_W    = 15;

  // Configuration port.
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAP0_LINEAR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP1_LINEAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP2_LINEAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP3_LINEAR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_TRANSLATIONS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_TRANSLATIONS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_THRESHOLDS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_TRANSFORM = 3'd7;

  localparam int THRESH_W  = 48;

  // Frame geometry defaults.
  localparam int FRAME_WIDTH_DEF  = 256;
  localparam int FRAME_HEIGHT_DEF = 256;

  // One operation of the shared multiply-accumulate unit.
  typedef struct packed {
    logic                     en;
    logic                     clear;    // start a new sum from addend
    logic signed [COEF_W-1:0] coef;
    logic signed [PT_W-1:0]   operand;
    logic signed [ACC_W-1:0]  addend;
  } mac_op_t;

endpackage

@@ rtl/ifs_chaos_game_point_plotter.sv @@
// ----------------------------------------------------------------------------
// ifs_chaos_game_point_plotter: iterated function system chaos-game plotter
// Applies one of four configurable affine maps to a stored point for every
// input transaction and reports the resulting pixel, its frame address and
// the running pixel extents.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream (s_tvalid/s_tready/s_tdata/s_tuser) carries a 15-bit
//   random value in s_tdata and a restart flag in s_tuser. A transaction with
//   restart set returns the point to the origin and clears the extents before
//   the map is applied. Each input transaction yields exactly one output
//   transaction on m_tvalid/m_tready/m_tdata/m_tuser.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   and must only change while the block is idle.
// Timing:
//   All six products of one point go through a single shared 16x20 multiplier,
//   one product per cycle, followed by the row-result step S_PYFIN and the
//   address-and-extents step S_OUT. The result is registered into the output
//   register in that last step, and the block takes no new item until the
//   step is done; s_tready is low while it works.
// Reset and stalls:
//   rst (synchronous) clears the point, extents, state and configuration
//   registers and drops m_tvalid. A finished result sits in the output
//   register until it is taken; the next input may be accepted meanwhile,
//   but its result then waits in its final step until the register frees up.
// ----------------------------------------------------------------------------
module ifs_chaos_game_point_plotter #(
  parameter int FRAME_WIDTH  = ifsc_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ifsc_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // [14:0] random_value, [15] zero
  input  logic                               s_tuser,   // [0] restart
  // Output stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] pixel_address, [31:16] pixel_x, [47:32] pixel_y, [63:48] least_x,
  // [79:64] greatest_x, [95:80] least_y, [111:96] greatest_y
  output logic [111:0]                       m_tdata,
  output logic                               m_tuser,   // [0] in_frame
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [ifsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ifsc_pkg::CFG_W-1:0]         cfg_data
);

  localparam int ACC_W  = ifsc_pkg::ACC_W;
  localparam int PT_W   = ifsc_pkg::PT_W;
  localparam int PIX_W  = ifsc_pkg::PIX_W;
  localparam int FB     = ifsc_pkg::FRAC_BITS;
  localparam int Q_W    = ACC_W - FB;   // integer part of the sum
  localparam int SUM_W  = Q_W + 1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FB - 1);
  localparam logic signed [SUM_W-1:0] PT_MAX  = SUM_W'((1 << (PT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] PT_MIN  = -SUM_W'(1 << (PT_W - 1));
  localparam logic signed [SUM_W-1:0] PIX_MAX = SUM_W'((1 << (PIX_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] PIX_MIN = -SUM_W'(1 << (PIX_W - 1));
  localparam logic signed [PIX_W-1:0] EXT_LOW_INIT  = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic signed [PIX_W-1:0] EXT_HIGH_INIT = {1'b1, {(PIX_W-1){1'b0}}};
  localparam logic signed [PIX_W:0]   WIDTH_LIM  = (PIX_W+1)'(FRAME_WIDTH);
  localparam logic signed [PIX_W:0]   HEIGHT_LIM = (PIX_W+1)'(FRAME_HEIGHT);
  localparam logic [PIX_W-1:0]        HEIGHT_MUL = PIX_W'(FRAME_HEIGHT);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AX    = 4'd1;
  localparam logic [3:0] S_BY    = 4'd2;
  localparam logic [3:0] S_CX    = 4'd3;
  localparam logic [3:0] S_DY    = 4'd4;
  localparam logic [3:0] S_PX    = 4'd5;
  localparam logic [3:0] S_PY    = 4'd6;
  localparam logic [3:0] S_PYFIN = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // Configuration registers.
  logic [ifsc_pkg::CFG_W-1:0]    map_linear [4];
  logic [ifsc_pkg::CFG_W-1:0]    x_translations;
  logic [ifsc_pkg::CFG_W-1:0]    y_translations;
  logic [ifsc_pkg::THRESH_W-1:0] map_thresholds;
  logic [ifsc_pkg::CFG_W-1:0]    view_transform;

  // Working state.
  logic [3:0]                    state;
  logic [1:0]                    map_sel;
  logic [1:0]                    map_pick;
  logic signed [PT_W-1:0]        point_x;
  logic signed [PT_W-1:0]        point_y;
  logic signed [PT_W-1:0]        new_x;
  logic signed [PIX_W-1:0]       pix_x;
  logic signed [PIX_W-1:0]       pix_y;
  logic signed [PIX_W-1:0]       ext_min_x;
  logic signed [PIX_W-1:0]       ext_max_x;
  logic signed [PIX_W-1:0]       ext_min_y;
  logic signed [PIX_W-1:0]       ext_max_y;

  // Output register.
  logic                          out_valid;
  logic [111:0]                  out_data;
  logic                          out_frame;

  ifsc_pkg::mac_op_t             mac_op;
  logic signed [ACC_W-1:0]       acc;

  logic [ifsc_pkg::CFG_W-1:0]    coef_word;
  logic signed [15:0]            trans_e;
  logic signed [15:0]            trans_f;
  logic [15:0]                   rand_ext;
  logic                          in_fire;
  logic                          out_free;
  logic signed [PT_W-1:0]        map_result;
  logic signed [PIX_W-1:0]       pix_result;
  logic signed [15:0]            trans_sel;
  logic signed [PIX_W-1:0]       min_x_next;
  logic signed [PIX_W-1:0]       max_x_next;
  logic signed [PIX_W-1:0]       min_y_next;
  logic signed [PIX_W-1:0]       max_y_next;
  logic                          in_view;
  logic [PIX_W-1:0]              address;

  // Round-to-Q6.14 (the half was added up front), add translation, saturate.
  function automatic logic signed [PT_W-1:0] finish_point(
    input logic signed [ACC_W-1:0] sum,
    input logic signed [15:0]      trans
  );
    logic signed [SUM_W-1:0] v;
    v = SUM_W'($signed(sum[ACC_W-1:FB])) + SUM_W'(trans);
    if (v > PT_MAX) begin
      finish_point = PT_MAX[PT_W-1:0];
    end else if (v < PT_MIN) begin
      finish_point = PT_MIN[PT_W-1:0];
    end else begin
      finish_point = v[PT_W-1:0];
    end
  endfunction

  // Drop the fraction toward zero and saturate to a 16-bit pixel coordinate.
  function automatic logic signed [PIX_W-1:0] finish_pixel(
    input logic signed [ACC_W-1:0] sum
  );
    logic signed [SUM_W-1:0] v;
    v = SUM_W'($signed(sum[ACC_W-1:FB]));
    if (sum[ACC_W-1] && (sum[FB-1:0] != '0)) begin
      v = v + SUM_W'(1);
    end
    if (v > PIX_MAX) begin
      finish_pixel = PIX_MAX[PIX_W-1:0];
    end else if (v < PIX_MIN) begin
      finish_pixel = PIX_MIN[PIX_W-1:0];
    end else begin
      finish_pixel = v[PIX_W-1:0];
    end
  endfunction

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_frame;

  // Map selection: the first threshold above the random value wins.
  assign rand_ext = {1'b0, s_tdata[ifsc_pkg::RAND_W-1:0]};
  always_comb begin
    priority if (rand_ext < map_thresholds[15:0]) begin
      map_pick = 2'd0;
    end else if (rand_ext < map_thresholds[31:16]) begin
      map_pick = 2'd1;
    end else if (rand_ext < map_thresholds[47:32]) begin
      map_pick = 2'd2;
    end else begin
      map_pick = 2'd3;
    end
  end

  assign coef_word = map_linear[map_sel];
  assign trans_e   = x_translations[{map_sel, 4'd0} +: 16];
  assign trans_f   = y_translations[{map_sel, 4'd0} +: 16];
  assign trans_sel = (state == S_CX) ? trans_e : trans_f;

  // The sum left in the accumulator by the previous step is finished here.
  assign map_result = finish_point(acc, trans_sel);
  assign pix_result = finish_pixel(acc);

  // Step schedule of the shared multiplier.
  always_comb begin
    mac_op         = '0;
    mac_op.addend  = ROUND_HALF;
    unique case (state)
      S_AX: begin
        mac_op.en      = 1'b1;
        mac_op.clear   = 1'b1;
        mac_op.coef    = coef_word[15:0];
        mac_op.operand = point_x;
      end
      S_BY: begin
        mac_op.en      = 1'b1;
        mac_op.coef    = coef_word[31:16];
        mac_op.operand = point_y;
      end
      S_CX: begin
        mac_op.en      = 1'b1;
        mac_op.clear   = 1'b1;
        mac_op.coef    = coef_word[47:32];
        mac_op.operand = point_x;
      end
      S_DY: begin
        mac_op.en      = 1'b1;
        mac_op.coef    = coef_word[63:48];
        mac_op.operand = point_y;
      end
      S_PX: begin
        mac_op.en      = 1'b1;
        mac_op.clear   = 1'b1;
        mac_op.coef    = view_transform[15:0];
        mac_op.operand = new_x;
        mac_op.addend  = {{(ACC_W-16-FB){view_transform[47]}}, view_transform[47:32],
                          {FB{1'b0}}};
      end
      S_PY: begin
        mac_op.en      = 1'b1;
        mac_op.clear   = 1'b1;
        mac_op.coef    = view_transform[31:16];
        mac_op.operand = point_y;
        mac_op.addend  = {{(ACC_W-16-FB){view_transform[63]}}, view_transform[63:48],
                          {FB{1'b0}}};
      end
      default: begin
        mac_op.en = 1'b0;
      end
    endcase
  end

  ifsc_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  // Extents include the current pixel; the frame test and address use it too.
  assign min_x_next = (pix_x < ext_min_x) ? pix_x : ext_min_x;
  assign max_x_next = (pix_x > ext_max_x) ? pix_x : ext_max_x;
  assign min_y_next = (pix_y < ext_min_y) ? pix_y : ext_min_y;
  assign max_y_next = (pix_y > ext_max_y) ? pix_y : ext_max_y;
  assign in_view    = ((PIX_W+1)'(pix_x) >= 0) && ((PIX_W+1)'(pix_x) < WIDTH_LIM) &&
                      ((PIX_W+1)'(pix_y) >= 0) && ((PIX_W+1)'(pix_y) < HEIGHT_LIM);
  assign address    = in_view ? PIX_W'(pix_x * HEIGHT_MUL + pix_y) : '0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        map_linear[i] <= '0;
      end
      x_translations <= '0;
      y_translations <= '0;
      map_thresholds <= '0;
      view_transform <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ifsc_pkg::REG_MAP0_LINEAR:    map_linear[0]  <= cfg_data;
        ifsc_pkg::REG_MAP1_LINEAR:    map_linear[1]  <= cfg_data;
        ifsc_pkg::REG_MAP2_LINEAR:    map_linear[2]  <= cfg_data;
        ifsc_pkg::REG_MAP3_LINEAR:    map_linear[3]  <= cfg_data;
        ifsc_pkg::REG_X_TRANSLATIONS: x_translations <= cfg_data;
        ifsc_pkg::REG_Y_TRANSLATIONS: y_translations <= cfg_data;
        ifsc_pkg::REG_MAP_THRESHOLDS: map_thresholds <= cfg_data[ifsc_pkg::THRESH_W-1:0];
        ifsc_pkg::REG_VIEW_TRANSFORM: view_transform <= cfg_data;
        default:                      map_thresholds <= map_thresholds;
      endcase
    end
  end

  // Sequencer, point and extents.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      point_x   <= '0;
      point_y   <= '0;
      ext_min_x <= EXT_LOW_INIT;
      ext_max_x <= EXT_HIGH_INIT;
      ext_min_y <= EXT_LOW_INIT;
      ext_max_y <= EXT_HIGH_INIT;
      out_valid <= 1'b0;
    end else begin
      // In the output step the register is refilled whenever it drains.
      if (out_valid && m_tready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            map_sel <= map_pick;
            if (s_tuser) begin
              point_x   <= '0;
              point_y   <= '0;
              ext_min_x <= EXT_LOW_INIT;
              ext_max_x <= EXT_HIGH_INIT;
              ext_min_y <= EXT_LOW_INIT;
              ext_max_y <= EXT_HIGH_INIT;
            end
            state <= S_AX;
          end
        end
        S_AX:    state <= S_BY;
        S_BY:    state <= S_CX;
        S_CX: begin
          new_x <= map_result;
          state <= S_DY;
        end
        S_DY:    state <= S_PX;
        S_PX: begin
          point_x <= new_x;
          point_y <= map_result;
          state   <= S_PY;
        end
        S_PY: begin
          pix_x <= pix_result;
          state <= S_PYFIN;
        end
        S_PYFIN: begin
          pix_y <= pix_result;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            ext_min_x <= min_x_next;
            ext_max_x <= max_x_next;
            ext_min_y <= min_y_next;
            ext_max_y <= max_y_next;
            out_valid <= 1'b1;
            out_frame <= in_view;
            out_data  <= {max_y_next, min_y_next, max_x_next, min_x_next,
                          pix_y, pix_x, address};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ifsc_mac.sv @@
// ----------------------------------------------------------------------------
// ifsc_mac: shared multiply-accumulate unit
// Multiplies a 16-bit coefficient by a 20-bit operand and either starts a new
// sum (product plus addend) or adds the product to the running sum.
// ----------------------------------------------------------------------------
module ifsc_mac (
  input  logic                                clk,
  input  ifsc_pkg::mac_op_t                   op,
  output logic signed [ifsc_pkg::ACC_W-1:0]   acc
);

  logic signed [ifsc_pkg::PROD_W-1:0] prod;
  logic signed [ifsc_pkg::ACC_W-1:0]  base;

  assign prod = op.coef * op.operand;
  assign base = op.clear ? op.addend : acc;

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= base + ifsc_pkg::ACC_W'(prod);
    end
  end

endmodule

@@ rtl/ifsc_checker.sv @@
// ----------------------------------------------------------------------------
// ifsc_checker: port-level checks for the chaos-game point plotter
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ifsc_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [111:0]                       m_tdata,
  input  logic                               m_tuser
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // After taking an item the block works on it before taking another.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // A pixel outside the frame carries a zero address.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[15:0] == 16'd0)
    else $error("address set for a pixel outside the frame");

  // The extents always enclose the reported pixel.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[63:48]) <= $signed(m_tdata[31:16]) &&
                 $signed(m_tdata[31:16]) <= $signed(m_tdata[79:64]) &&
                 $signed(m_tdata[95:80]) <= $signed(m_tdata[47:32]) &&
                 $signed(m_tdata[47:32]) <= $signed(m_tdata[111:96]))
    else $error("extents do not enclose the pixel");

endmodule

bind ifs_chaos_game_point_plotter ifsc_checker u_checker (.*);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the chaos-game point plotter
// Drives random values and restart flags into the input stream, mirrors the
// affine map, pixel and extent arithmetic in a local predictor, and compares
// every output transaction field by field. A short table of directed steps
// (register writes and items) runs first, then randomized register settings
// with random items. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int     FRAME_W      = 256;
  localparam int     FRAME_H      = 256;
  localparam longint ONE_Q        = 64'sd1 <<< ifsc_pkg::FRAC_BITS;
  localparam longint ROUND_HALF   = 64'sd1 <<< (ifsc_pkg::FRAC_BITS - 1);
  localparam longint POINT_MAX    = 524287;
  localparam longint POINT_MIN    = -524288;
  localparam int     PHASES       = 10;
  localparam int     PHASE_ITEMS  = 65;
  localparam int     HOLD_CYCLES  = 80;
  localparam int     PRINT_LIMIT  = 50;

  // How the registers of one random phase are chosen.
  typedef enum int {
    STYLE_TAME,      // contracting maps, ordered thresholds, pixels near the frame
    STYLE_WILD,      // every register bit random
    STYLE_ALL_ONES,  // every register written with all ones
    STYLE_MAX_POS    // largest positive coefficients, offsets and scales
  } cfg_style_t;

  // One output transaction as the predictor sees it.
  typedef struct packed {
    logic [15:0]        addr;
    logic               in_frame;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] lx;
    logic signed [15:0] gx;
    logic signed [15:0] ly;
    logic signed [15:0] gy;
  } plot_result_t;

  // One row of the directed table: either a register write or an item.
  typedef struct packed {
    bit           wr;
    logic [2:0]   idx;
    logic [63:0]  val;
    logic [14:0]  rnd;
    logic         rs;
    bit           known;    // expectation typed in rather than predicted
    plot_result_t want;
  } stim_row_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata   = '0;
  logic         s_tuser   = 1'b0;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [111:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we    = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data  = '0;

  // Predictor copy of the registers and the plotter state.
  logic [63:0]        lin_coefs [4] = '{default: '0};
  logic [63:0]        x_shift     = '0;
  logic [63:0]        y_shift     = '0;
  logic [47:0]        thresholds  = '0;
  logic [63:0]        view_regs   = '0;
  logic signed [19:0] pt_x        = '0;
  logic signed [19:0] pt_y        = '0;
  logic signed [15:0] min_x       = 16'sh7FFF;
  logic signed [15:0] max_x       = 16'sh8000;
  logic signed [15:0] min_y       = 16'sh7FFF;
  logic signed [15:0] max_y       = 16'sh8000;

  plot_result_t pending_pixels [$];
  stim_row_t    plan [$];

  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned restarts_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned inside_seen   = 0;
  int unsigned settings_used = 0;

  // The stimulus asks the receiver for one long hold-off; the receiver
  // counts it out and then reports back.
  bit sink_hold_req  = 1'b0;
  bit sink_hold_done = 1'b0;

  always #5 clk = ~clk;

  ifs_chaos_game_point_plotter #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [14:0] random_value, [15] zero
    .s_tuser   (s_tuser),   // [0] restart
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    // [15:0] pixel_address, [31:16] pixel_x, [47:32] pixel_y, [63:48] least_x,
    // [79:64] greatest_x, [95:80] least_y, [111:96] greatest_y
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),   // [0] in_frame
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Signed halfword n of a 64-bit register.
  function automatic longint half_signed(input logic [63:0] w, input int n);
    logic signed [15:0] h;
    h = w[16*n +: 16];
    return h;
  endfunction

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Applies one chaos-game step to the predictor state and returns the pixel
  // transaction that the block should produce for it.
  function automatic plot_result_t advance_point(input logic [14:0] rnd, input logic rs);
    plot_result_t res;
    int           sel;
    longint       nx, ny, px, py;
    logic         on_frame;
    if (rs) begin
      pt_x  = '0;
      pt_y  = '0;
      min_x = 16'sh7FFF;
      max_x = 16'sh8000;
      min_y = 16'sh7FFF;
      max_y = 16'sh8000;
    end
    // The first threshold that exceeds the random value picks the map; with
    // unordered thresholds some maps simply can never be reached.
    if (rnd < thresholds[15:0])       sel = 0;
    else if (rnd < thresholds[31:16]) sel = 1;
    else if (rnd < thresholds[47:32]) sel = 2;
    else                              sel = 3;
    // Exact sum of products, rounded half up back to Q6.14 (the shift floors).
    nx = ((half_signed(lin_coefs[sel], 0) * pt_x + half_signed(lin_coefs[sel], 1) * pt_y
           + ROUND_HALF) >>> ifsc_pkg::FRAC_BITS) + half_signed(x_shift, sel);
    ny = ((half_signed(lin_coefs[sel], 2) * pt_x + half_signed(lin_coefs[sel], 3) * pt_y
           + ROUND_HALF) >>> ifsc_pkg::FRAC_BITS) + half_signed(y_shift, sel);
    pt_x = 20'(saturate(nx, POINT_MIN, POINT_MAX));
    pt_y = 20'(saturate(ny, POINT_MIN, POINT_MAX));
    // Pixel: scale and offset in Q.14, then the division truncates toward zero.
    px = (longint'(pt_x) * half_signed(view_regs, 0) + half_signed(view_regs, 2) * ONE_Q) / ONE_Q;
    py = (longint'(pt_y) * half_signed(view_regs, 1) + half_signed(view_regs, 3) * ONE_Q) / ONE_Q;
    px = saturate(px, -32768, 32767);
    py = saturate(py, -32768, 32767);
    if (px < min_x) min_x = 16'(px);
    if (px > max_x) max_x = 16'(px);
    if (py < min_y) min_y = 16'(py);
    if (py > max_y) max_y = 16'(py);
    on_frame = (px >= 0) && (px < FRAME_W) && (py >= 0) && (py < FRAME_H);
    res.addr     = on_frame ? 16'(px * FRAME_H + py) : 16'd0;
    res.in_frame = on_frame;
    res.px       = 16'(px);
    res.py       = 16'(py);
    res.lx       = min_x;
    res.gx       = max_x;
    res.ly       = min_y;
    res.gy       = max_y;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %0d expected %0d",
                              results_seen, name, $signed(got), $signed(want)));
  endtask

  // Every output transaction is matched against the oldest expectation.
  always @(posedge clk) begin : watch_results
    plot_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("output transaction with no pixel expected");
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_address", m_tdata[15:0],   want.addr);
        check_field("in_frame",      16'(m_tuser),    16'(want.in_frame));
        check_field("pixel_x",       m_tdata[31:16],  want.px);
        check_field("pixel_y",       m_tdata[47:32],  want.py);
        check_field("least_x",       m_tdata[63:48],  want.lx);
        check_field("greatest_x",    m_tdata[79:64],  want.gx);
        check_field("least_y",       m_tdata[95:80],  want.ly);
        check_field("greatest_y",    m_tdata[111:96], want.gy);
        if (want.in_frame) inside_seen++;
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Idle pattern shared by both sides: mostly none, sometimes short, rarely long.
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request so that the
  // block fills up and has to push back on its input.
  initial begin : drain_side
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req && !sink_hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold_done = 1'b1;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Offers one item, waits for its transaction, records what it should yield,
  // then idles for a random gap (none while the receiver is held off).
  task automatic offer_item(input logic [14:0] rnd, input logic rs,
                            input bit known, input plot_result_t want);
    plot_result_t predicted;
    int unsigned  gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, rnd};
    s_tuser  <= rs;
    do @(posedge clk); while (s_tready !== 1'b1);
    predicted = advance_point(rnd, rs);
    pending_pixels.push_back(known ? want : predicted);
    items_sent++;
    if (rs) restarts_sent++;
    gap = (sink_hold_req && !sink_hold_done) ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected pixel has come out. Each
  // item yields a result, so once all have come out the block is idle.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_we after its last write.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      ifsc_pkg::REG_MAP0_LINEAR:    lin_coefs[0] = val;
      ifsc_pkg::REG_MAP1_LINEAR:    lin_coefs[1] = val;
      ifsc_pkg::REG_MAP2_LINEAR:    lin_coefs[2] = val;
      ifsc_pkg::REG_MAP3_LINEAR:    lin_coefs[3] = val;
      ifsc_pkg::REG_X_TRANSLATIONS: x_shift      = val;
      ifsc_pkg::REG_Y_TRANSLATIONS: y_shift      = val;
      ifsc_pkg::REG_MAP_THRESHOLDS: thresholds   = val[47:0];
      ifsc_pkg::REG_VIEW_TRANSFORM: view_regs    = val;
      default: ;
    endcase
  endtask

  // Helpers that fill the directed table.
  task automatic add_write(input logic [2:0] idx, input logic [63:0] val);
    stim_row_t row;
    row     = '0;
    row.wr  = 1'b1;
    row.idx = idx;
    row.val = val;
    plan.push_back(row);
  endtask

  task automatic add_item(input logic [14:0] rnd, input logic rs);
    stim_row_t row;
    row     = '0;
    row.rnd = rnd;
    row.rs  = rs;
    plan.push_back(row);
  endtask

  task automatic add_known(input logic [14:0] rnd, input logic rs, input int addr,
                           input int inf, input int px, input int py, input int lx,
                           input int gx, input int ly, input int gy);
    stim_row_t row;
    row               = '0;
    row.rnd           = rnd;
    row.rs            = rs;
    row.known         = 1'b1;
    row.want.addr     = 16'(addr);
    row.want.in_frame = inf[0];
    row.want.px       = 16'(px);
    row.want.py       = 16'(py);
    row.want.lx       = 16'(lx);
    row.want.gx       = 16'(gx);
    row.want.ly       = 16'(ly);
    row.want.gy       = 16'(gy);
    plan.push_back(row);
  endtask

  // Random coefficient in [-span, span], as a Q2.14 halfword.
  function automatic logic [15:0] tame_half(input int span);
    return 16'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bit          prev_wr;
    cfg_style_t  style;
    logic [63:0] words [8];
    int          t0, t1, t2;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. With every register at its reset value of zero, the
    // point never leaves the origin and the pixel equals the view offset, so
    // those rows carry their expected results directly. The first item
    // restarts before any step has happened.
    add_known(15'd0,     1'b1, 0, 1, 0, 0, 0, 0, 0, 0);
    add_known(15'h7FFF,  1'b0, 0, 1, 0, 0, 0, 0, 0, 0);
    // Offsets only: x offset -5, y offset 300, both outside the frame.
    add_write(ifsc_pkg::REG_VIEW_TRANSFORM, {16'd300, 16'hFFFB, 16'd0, 16'd0});
    add_known(15'd100,   1'b0, 0, 0, -5, 300, -5, 0, 0, 300);
    // Far corner of the frame: the largest address.
    add_write(ifsc_pkg::REG_VIEW_TRANSFORM, {16'd255, 16'd255, 16'd0, 16'd0});
    add_known(15'd200,   1'b1, 65535, 1, 255, 255, 255, 255, 255, 255);
    // Most negative column and most positive row.
    add_write(ifsc_pkg::REG_VIEW_TRANSFORM, {16'h7FFF, 16'h8000, 16'd0, 16'd0});
    add_known(15'd300,   1'b0, 0, 0, -32768, 32767, -32768, 255, 255, 32767);
    // One column past the right edge.
    add_write(ifsc_pkg::REG_VIEW_TRANSFORM, {16'd0, 16'd256, 16'd0, 16'd0});
    add_known(15'd400,   1'b1, 0, 0, 256, 0, 256, 256, 0, 0);

    // A Sierpinski-like set of maps, half-scale for maps 0 and 1; items sit on
    // both sides of every threshold.
    add_write(ifsc_pkg::REG_MAP_THRESHOLDS, 64'({16'd24576, 16'd16384, 16'd8192}));
    add_write(ifsc_pkg::REG_MAP0_LINEAR,    {16'd8192, 16'd0, 16'd0, 16'd8192});
    add_write(ifsc_pkg::REG_MAP1_LINEAR,    {16'd8192, 16'd0, 16'd0, 16'd8192});
    add_write(ifsc_pkg::REG_MAP2_LINEAR,    {16'd8192, 16'hF000, 16'd2048, 16'd8192});
    add_write(ifsc_pkg::REG_MAP3_LINEAR,    {16'd4096, 16'd4096, 16'hF000, 16'hE000});
    add_write(ifsc_pkg::REG_X_TRANSLATIONS, {16'hC000, 16'd4096, 16'd8192, 16'd0});
    add_write(ifsc_pkg::REG_Y_TRANSLATIONS, {16'd16384, 16'd8192, 16'd0, 16'd0});
    add_write(ifsc_pkg::REG_VIEW_TRANSFORM, {16'd20, 16'd128, 16'd100, 16'd100});
    add_item(15'd0,     1'b1);
    add_item(15'd8191,  1'b0);
    add_item(15'd8192,  1'b0);
    add_item(15'd16383, 1'b0);
    add_item(15'd16384, 1'b0);
    add_item(15'd24575, 1'b0);
    add_item(15'd24576, 1'b0);
    add_item(15'h7FFF,  1'b0);
    add_item(15'd12345, 1'b1);

    // Largest coefficients and translations with full-scale view: the point
    // runs into its saturation limit and so do both pixel coordinates.
    add_write(ifsc_pkg::REG_MAP0_LINEAR,    64'h7FFF_7FFF_7FFF_7FFF);
    add_write(ifsc_pkg::REG_X_TRANSLATIONS, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(ifsc_pkg::REG_Y_TRANSLATIONS, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(ifsc_pkg::REG_MAP_THRESHOLDS, 64'h0000_FFFF_FFFF_FFFF);
    add_write(ifsc_pkg::REG_VIEW_TRANSFORM, {16'd0, 16'd0, 16'h8000, 16'h7FFF});
    add_item(15'd1,     1'b1);
    add_item(15'd2,     1'b0);
    add_item(15'd3,     1'b0);
    add_item(15'd4,     1'b0);

    // Unordered thresholds leave map 1 unreachable.
    add_write(ifsc_pkg::REG_MAP_THRESHOLDS, 64'({16'd30000, 16'd10000, 16'd20000}));
    add_item(15'd15000, 1'b1);
    add_item(15'd25000, 1'b0);
    add_item(15'd30000, 1'b0);
    add_item(15'd5000,  1'b0);
    // All thresholds zero: every value picks map 3.
    add_write(ifsc_pkg::REG_MAP_THRESHOLDS, 64'd0);
    add_item(15'd0,     1'b0);

    prev_wr = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].wr) begin
        if (!prev_wr) wait_for_results();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (prev_wr) cfg_we <= 1'b0;
        offer_item(plan[i].rnd, plan[i].rs, plan[i].known, plan[i].want);
      end
      prev_wr = plan[i].wr;
    end

    // Random phases: each starts idle, rewrites every register, then streams
    // items with occasional restarts.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      case (phase)
        3, 9:    style = STYLE_WILD;
        4:       style = STYLE_ALL_ONES;
        7:       style = STYLE_MAX_POS;
        default: style = STYLE_TAME;
      endcase
      for (int k = 0; k < 8; k++) words[k] = {$urandom, $urandom};
      case (style)
        STYLE_TAME: begin
          for (int k = 0; k < 4; k++)
            words[ifsc_pkg::REG_MAP0_LINEAR + k] = {tame_half(9830), tame_half(9830),
                                                    tame_half(9830), tame_half(9830)};
          words[ifsc_pkg::REG_X_TRANSLATIONS] = {tame_half(16384), tame_half(16384),
                                                 tame_half(16384), tame_half(16384)};
          words[ifsc_pkg::REG_Y_TRANSLATIONS] = {tame_half(16384), tame_half(16384),
                                                 tame_half(16384), tame_half(16384)};
          t0 = $urandom_range(0, 16000);
          t1 = t0 + $urandom_range(0, 10000);
          t2 = t1 + $urandom_range(0, 8000);
          words[ifsc_pkg::REG_MAP_THRESHOLDS] = 64'({16'(t2), 16'(t1), 16'(t0)});
          words[ifsc_pkg::REG_VIEW_TRANSFORM] = {16'($urandom_range(64, 192)),
                                                 16'($urandom_range(64, 192)),
                                                 16'($urandom_range(20, 120)),
                                                 16'($urandom_range(20, 120))};
        end
        STYLE_ALL_ONES: begin
          for (int k = 0; k < 8; k++) words[k] = '1;
        end
        STYLE_MAX_POS: begin
          for (int k = 0; k < 8; k++) words[k] = 64'h7FFF_7FFF_7FFF_7FFF;
          words[ifsc_pkg::REG_MAP_THRESHOLDS] = 64'({16'($urandom_range(16384, 32767)),
                                                     16'($urandom_range(0, 16383)),
                                                     16'($urandom_range(0, 8191))});
        end
        default: ;
      endcase
      for (int k = 0; k < 8; k++) write_reg(3'(k), words[k]);
      cfg_we <= 1'b0;
      settings_used++;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold-off while the sender keeps offering.
        if (phase == 2 && n == 5) sink_hold_req = 1'b1;
        // Sender pauses until every pending pixel has arrived.
        if (phase == 6 && n == 30) wait_for_results();
        offer_item(15'($urandom_range(0, 32767)), ($urandom_range(0, 39) == 0),
                   1'b0, '0);
      end
    end

    wait_for_results();
    repeat (16) @(posedge clk);

    $display("Checked %0d pixel transactions from %0d items (%0d restarts, %0d in frame)",
             results_seen, items_sent, restarts_sent, inside_seen);
    $display("over the directed table and %0d random register settings.", settings_used);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake; far above the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("Timeout with %0d pixels still pending", pending_pixels.size());
    $display("status: fail");
    $finish;
  end

endmodule

@@ ifs_chaos_game_point_plotter.f @@
rtl/ifsc_pkg.sv
rtl/ifsc_mac.sv
rtl/ifs_chaos_game_point_plotter.sv
rtl/ifsc_checker.sv
bench/testbench.sv
